### sv/scdec_pkg.sv
// ----------------------------------------------------------------------------
// scdec_pkg
// shared types, key codes and translation tables for the scan-code decoder
// ----------------------------------------------------------------------------
package scdec_pkg;

    typedef logic [7:0] code_t;
    typedef logic [6:0] value_t;

    typedef enum logic [1:0] {
        EV_CHAR   = 2'd0,
        EV_SWITCH = 2'd1,
        EV_DEBUG  = 2'd2
    } event_kind_t;

    // input register contents handed to the decoder
    typedef struct packed {
        logic  valid;
        code_t code;
    } stage_t;

    // decoded result, hit is low when the code gives nothing
    typedef struct packed {
        logic        hit;
        event_kind_t kind;
        value_t      value;
    } result_t;

    localparam code_t KEY_RELEASE = 8'h80;
    localparam code_t KEY_ESC     = 8'h01;
    localparam code_t KEY_LSHIFT  = 8'd42;
    localparam code_t KEY_RSHIFT  = 8'd54;
    localparam code_t KEY_CONTROL = 8'h1d;
    localparam code_t KEY_ALT     = 8'h38;
    localparam code_t KEY_F1      = 8'h3b;
    localparam code_t KEY_F10     = 8'h44;
    localparam code_t TABLE_LIMIT = 8'd59;

    localparam value_t CHAR_LOWER_A = 7'h61;
    localparam value_t CHAR_LOWER_Z = 7'h7a;
    localparam value_t CTRL_OFFSET  = 7'h60;

    // tables padded to 64 entries so a 6-bit index is always in range
    localparam value_t PLAIN_MAP [64] = '{
        7'h20, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h20, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
        7'h27, 7'h60, 7'h20, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h20, 7'h20,
        7'h20, 7'h20, 7'h20, 7'h20, 7'h20, 7'h20, 7'h20, 7'h20
    };

    localparam value_t UPPER_MAP [64] = '{
        7'h20, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e,
        7'h26, 7'h2a, 7'h28, 7'h29, 7'h5f, 7'h2b, 7'h20, 7'h20,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h20, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
        7'h22, 7'h7e, 7'h20, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h20, 7'h20,
        7'h20, 7'h20, 7'h20, 7'h20, 7'h20, 7'h20, 7'h20, 7'h20
    };

endpackage

### sv/scdec_code_if.sv
// ----------------------------------------------------------------------------
// scdec_code_if
// scan-code request channel: valid, ready and one raw set-1 byte
// ----------------------------------------------------------------------------
interface scdec_code_if;
    import scdec_pkg::*;

    logic  valid;
    logic  ready;
    code_t scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);

endinterface

### sv/scdec_event_if.sv
// ----------------------------------------------------------------------------
// scdec_event_if
// decoded event channel: valid, ready, event kind and value
// ----------------------------------------------------------------------------
interface scdec_event_if;
    import scdec_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    value_t     event_value;

    modport source (output valid, output event_kind, output event_value, input ready);
    modport sink   (input valid, input event_kind, input event_value, output ready);

endinterface

### sv/scancode_to_ascii_decoder_core.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_decoder_core
// set-1 scan codes in, characters and console events out
// ----------------------------------------------------------------------------
// channel   dir   payload                          use
// keys      in    scan_code[7:0]                   one raw set-1 byte per request
// events    out   event_kind[1:0], event_value[6:0] char, console switch or debug
//
// one scan code per cycle sustained while events does not stall
// the path is input register, one decode pass, result register
// codes that give no result (modifiers, breaks, unmapped) are dropped
// rst_n clears both valid bits and the shift, control and alt flags
// a stall on events holds the result and backs up into keys only when full
// ----------------------------------------------------------------------------
module scancode_to_ascii_decoder_core (
    input  logic           clk,
    input  logic           rst_n,
    scdec_code_if.sink     keys,
    scdec_event_if.source  events
);
    import scdec_pkg::*;

    stage_t  stage;
    result_t res;
    logic    space;
    logic    take;

    assign take = stage.valid && space;

    scdec_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .keys  (keys),
        .take  (take),
        .stage (stage)
    );

    scdec_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .stage (stage),
        .take  (take),
        .res   (res)
    );

    scdec_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .res    (res),
        .load   (take),
        .space  (space),
        .events (events)
    );

endmodule

### sv/scdec_in_reg.sv
// ----------------------------------------------------------------------------
// scdec_in_reg
// input register holding one scan code until the decoder takes it
// ----------------------------------------------------------------------------
module scdec_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    scdec_code_if.sink         keys,
    input  logic               take,
    output scdec_pkg::stage_t  stage
);
    import scdec_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    code_t code_reg;
    logic  accept;

    assign keys.ready = !valid_reg || take;
    assign accept     = keys.valid && keys.ready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg <= keys.scan_code;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.code  = code_reg;

endmodule

### sv/scdec_decode.sv
// ----------------------------------------------------------------------------
// scdec_decode
// modifier flags and the single-pass translation of one scan code
// ----------------------------------------------------------------------------
module scdec_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  scdec_pkg::stage_t  stage,
    input  logic               take,
    output scdec_pkg::result_t res
);
    import scdec_pkg::*;

    logic   shift_held_reg;
    logic   shift_held_next;
    logic   control_held_reg;
    logic   control_held_next;
    logic   alt_held_reg;
    logic   alt_held_next;
    code_t  code;
    value_t plain_ch;
    value_t upper_ch;

    assign code     = stage.code;
    assign plain_ch = PLAIN_MAP[code[5:0]];
    assign upper_ch = UPPER_MAP[code[5:0]];

    always_comb
    begin
        res               = '0;
        res.kind          = EV_CHAR;
        shift_held_next   = shift_held_reg;
        control_held_next = control_held_reg;
        alt_held_next     = alt_held_reg;

        priority if (alt_held_reg && code == KEY_ESC)
        begin
            res.hit       = 1'b1;
            res.kind      = EV_DEBUG;
            alt_held_next = 1'b0;
        end
        else if (code >= KEY_F1 && code <= KEY_F10)
        begin
            res.hit   = 1'b1;
            res.kind  = EV_SWITCH;
            res.value = code[6:0] - KEY_F1[6:0];
        end
        else if (code == KEY_ALT)
        begin
            alt_held_next = 1'b1;
        end
        else if (code == (KEY_ALT | KEY_RELEASE))
        begin
            alt_held_next = 1'b0;
        end
        else if (code == KEY_CONTROL)
        begin
            control_held_next = 1'b1;
        end
        else if (code == (KEY_CONTROL | KEY_RELEASE))
        begin
            control_held_next = 1'b0;
        end
        else if (code == KEY_LSHIFT || code == KEY_RSHIFT)
        begin
            shift_held_next = 1'b1;
        end
        else if (code == (KEY_LSHIFT | KEY_RELEASE) || code == (KEY_RSHIFT | KEY_RELEASE))
        begin
            shift_held_next = 1'b0;
        end
        else if ((code & KEY_RELEASE) != '0 || code >= TABLE_LIMIT)
        begin
            res.hit = 1'b0;
        end
        else if (control_held_reg)
        begin
            // only letters pass, as control codes 1 to 26
            if (plain_ch >= CHAR_LOWER_A && plain_ch <= CHAR_LOWER_Z)
            begin
                res.hit   = 1'b1;
                res.value = plain_ch - CTRL_OFFSET;
            end
        end
        else
        begin
            res.hit   = 1'b1;
            res.value = shift_held_reg ? upper_ch : plain_ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_held_reg   <= 1'b0;
            control_held_reg <= 1'b0;
            alt_held_reg     <= 1'b0;
        end
        else if (take)
        begin
            shift_held_reg   <= shift_held_next;
            control_held_reg <= control_held_next;
            alt_held_reg     <= alt_held_next;
        end
    end

`ifndef SYNTHESIS
    a_debug_clears_alt: assert property (@(posedge clk) disable iff (!rst_n)
        (take && res.hit && res.kind == EV_DEBUG) |=> !alt_held_reg)
        else $error("debug request left alt held");

    a_switch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (stage.valid && res.hit && res.kind == EV_SWITCH) |-> res.value <= 7'd9)
        else $error("console number out of range");

    a_ctrl_letter: assert property (@(posedge clk) disable iff (!rst_n)
        (stage.valid && res.hit && res.kind == EV_CHAR && control_held_reg)
        |-> (res.value >= 7'd1 && res.value <= 7'd26))
        else $error("control held but value is not a control code");

    a_shift_break: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (code == (KEY_LSHIFT | KEY_RELEASE) || code == (KEY_RSHIFT | KEY_RELEASE)))
        |=> !shift_held_reg)
        else $error("shift break did not clear shift");
`endif

endmodule

### sv/scdec_out_reg.sv
// ----------------------------------------------------------------------------
// scdec_out_reg
// result register driving the event channel
// ----------------------------------------------------------------------------
module scdec_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  scdec_pkg::result_t  res,
    input  logic                load,
    output logic                space,
    scdec_event_if.source       events
);
    import scdec_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    event_kind_t kind_reg;
    value_t      value_reg;

    assign space = !valid_reg || events.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = res.hit;
        end
        else if (events.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.hit)
        begin
            kind_reg  <= res.kind;
            value_reg <= res.value;
        end
    end

    assign events.valid       = valid_reg;
    assign events.event_kind  = kind_reg;
    assign events.event_value = value_reg;

endmodule
